[rtl/assert_macros.svh]
// Assertion helper macros for the blob finder RTL.
// Included by the top level; set NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SBF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SBF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SBF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/sbf_pkg.sv]
// Shared widths, register indexes and the CORDIC angle table for the blob finder.
// No dependencies.
package sbf_pkg;

   localparam int COLOR_W  = 24;
   localparam int RANGE_W  = 16;
   localparam int HEIGHT_W = 10;
   localparam int FOV_W    = 12;
   localparam int HALF_W   = 12;
   localparam int CSR_W    = 12;
   localparam int CSR_IDX_W = 2;
   localparam int EDGE_W   = 8;
   localparam int ID_W     = 7;
   localparam int AREA_W   = 18;

   // CORDIC datapath
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_XY_W  = 36;
   localparam int CORDIC_Z_W   = 19;
   localparam int ANGLE_W      = 17;

   // k = ((z * H * 1000) >> 16) / fov
   localparam int PROD1_W = ANGLE_W + HEIGHT_W;
   localparam int PROD2_W = PROD1_W + 10;
   localparam int QUO_W   = PROD2_W - 16;
   localparam int SCALE_MM = 1000;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VFOV         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HEIGHT  = 2'd2;

   localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 10'd120;
   localparam logic [FOV_W-1:0]    RST_VFOV         = 12'd1047;
   localparam logic [HALF_W-1:0]   RST_HALF_HEIGHT  = 12'd300;

   // atan(2^-i) in Q0.16
   function automatic logic [15:0] atan_q16(input logic [3:0] i);
      logic [15:0] v;
      unique case (i)
         4'd0:  v = 16'd51472;
         4'd1:  v = 16'd30385;
         4'd2:  v = 16'd16055;
         4'd3:  v = 16'd8150;
         4'd4:  v = 16'd4091;
         4'd5:  v = 16'd2047;
         4'd6:  v = 16'd1024;
         4'd7:  v = 16'd512;
         4'd8:  v = 16'd256;
         4'd9:  v = 16'd128;
         4'd10: v = 16'd64;
         4'd11: v = 16'd32;
         4'd12: v = 16'd16;
         4'd13: v = 16'd8;
         4'd14: v = 16'd4;
         4'd15: v = 16'd2;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/sbf_cordic.sv]
// Iterative vectoring CORDIC: atan2(y, x) in Q1.16, one micro-rotation per cycle.
// Uses sbf_pkg for widths and the angle table.
module sbf_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [sbf_pkg::HALF_W-1:0]          y_in,
   input  logic [sbf_pkg::RANGE_W-1:0]         x_in,
   output logic                                done,
   output logic [sbf_pkg::ANGLE_W-1:0]         angle
);

   logic signed [sbf_pkg::CORDIC_XY_W-1:0] x_ff, y_ff, xs, ys;
   logic signed [sbf_pkg::CORDIC_Z_W-1:0]  z_ff, step_angle;
   logic [3:0] iter_ff;
   logic       busy_ff, done_ff, zero_ff;

   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;
   assign step_angle = $signed({3'b000, sbf_pkg::atan_q16(iter_ff)});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff    <= $signed({4'b0000, x_in, 16'h0000});
            y_ff    <= $signed({8'h00, y_in, 16'h0000});
            z_ff    <= '0;
            iter_ff <= '0;
            zero_ff <= (y_in == '0);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (y_ff > 0) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + step_angle;
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - step_angle;
            end
            iter_ff <= iter_ff + 4'd1;
            if (iter_ff == 4'(sbf_pkg::CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done  = done_ff;
   assign angle = (zero_ff || z_ff[sbf_pkg::CORDIC_Z_W-1]) ? '0 : z_ff[sbf_pkg::ANGLE_W-1:0];

endmodule

[rtl/sbf_divider.sv]
// Restoring divider, one quotient bit per cycle, for the vertical extent.
// Uses sbf_pkg for widths.
module sbf_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sbf_pkg::QUO_W-1:0]      numer,
   input  logic [sbf_pkg::FOV_W-1:0]      denom,
   output logic                           done,
   output logic [sbf_pkg::QUO_W-1:0]      quot
);

   logic [sbf_pkg::QUO_W-1:0] quo_ff;
   logic [sbf_pkg::FOV_W-1:0] rem_ff, den_ff;
   logic [sbf_pkg::FOV_W:0]   trial;
   logic [4:0] cnt_ff;
   logic       busy_ff, done_ff;

   assign trial = {rem_ff, quo_ff[sbf_pkg::QUO_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= numer;
            rem_ff  <= '0;
            den_ff  <= denom;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= sbf_pkg::FOV_W'(trial - {1'b0, den_ff});
               quo_ff <= {quo_ff[sbf_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[sbf_pkg::FOV_W-1:0];
               quo_ff <= {quo_ff[sbf_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(sbf_pkg::QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[rtl/scanline_color_blob_finder_core.sv]
// Scan-line color blob finder: run detection, line store, blob geometry sequencer.
// Uses sbf_pkg, sbf_cordic, sbf_divider and assert_macros.svh.
// A beat that closes no blob visits the idle, held and last states; each emitted
// blob adds a 16-step CORDIC, 21-step divide, line store reads, output handshake.
// End of line adds the FINAL and EOL states and output wait. Not ready while busy.
// Synchronous reset clears the run state and counters and loads config defaults.
module scanline_color_blob_finder_core #(
   parameter int LINE_WIDTH = 256,
   parameter int MAX_BLOBS  = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [sbf_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [sbf_pkg::CSR_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_pixel_hit,
   input  logic [sbf_pkg::COLOR_W-1:0]       req_pixel_color,
   input  logic [sbf_pkg::RANGE_W-1:0]       req_pixel_range_mm,
   input  logic                              req_last_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_blob,
   output logic [sbf_pkg::ID_W-1:0]          rsp_blob_id,
   output logic [sbf_pkg::COLOR_W-1:0]       rsp_blob_color,
   output logic [sbf_pkg::EDGE_W-1:0]        rsp_x_center,
   output logic [8:0]                        rsp_y_center,
   output logic [sbf_pkg::EDGE_W-1:0]        rsp_left_edge,
   output logic [sbf_pkg::EDGE_W-1:0]        rsp_right_edge,
   output logic [sbf_pkg::HEIGHT_W-1:0]      rsp_top_edge,
   output logic [sbf_pkg::HEIGHT_W-1:0]      rsp_bottom_edge,
   output logic [sbf_pkg::AREA_W-1:0]        rsp_blob_area,
   output logic [sbf_pkg::RANGE_W-1:0]       rsp_blob_range_mm,
   output logic                              rsp_last
);

   localparam int IDX_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
   localparam int CNT_W = $clog2(MAX_BLOBS + 1);
   localparam int MEM_W = sbf_pkg::RANGE_W + 1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_HELD, ST_LAST, ST_FINAL, ST_EOL,
      ST_BLOB_START, ST_RD_CTR, ST_CHK_CTR, ST_RD_LEFT, ST_GET_LEFT,
      ST_CORDIC, ST_CORDIC_WAIT, ST_MUL_H, ST_MUL_K, ST_DIV, ST_DIV_WAIT,
      ST_EDGES, ST_LOAD, ST_OUT
   } state_type;

   state_type state_ff, ret_ff;

   // configuration
   logic [sbf_pkg::HEIGHT_W-1:0] image_height_ff;
   logic [sbf_pkg::FOV_W-1:0]    vfov_ff;
   logic [sbf_pkg::HALF_W-1:0]   half_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff <= sbf_pkg::RST_IMAGE_HEIGHT;
         vfov_ff         <= sbf_pkg::RST_VFOV;
         half_height_ff  <= sbf_pkg::RST_HALF_HEIGHT;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            sbf_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wr_data[sbf_pkg::HEIGHT_W-1:0];
            sbf_pkg::CSR_VFOV:         vfov_ff <= csr_wr_data;
            sbf_pkg::CSR_HALF_HEIGHT:  half_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // line state
   logic [IDX_W-1:0]             idx_ff, run_left_ff, blob_right_ff, xc_ff;
   logic                         run_active_ff, held_valid_ff, held_hit_ff;
   logic [sbf_pkg::COLOR_W-1:0]  run_color_ff, held_color_ff, cur_color_ff;
   logic                         cur_hit_ff, cur_last_ff;
   logic [CNT_W-1:0]             blob_count_ff;

   // blob datapath
   logic [sbf_pkg::RANGE_W-1:0]  rng_ff;
   logic [sbf_pkg::ANGLE_W-1:0]  z_ff;
   logic [sbf_pkg::PROD1_W-1:0]  p1_ff;
   logic [sbf_pkg::PROD2_W-1:0]  p2_ff;
   logic [sbf_pkg::QUO_W-1:0]    k_ff;
   logic [sbf_pkg::HEIGHT_W-1:0] top_ff, bot_ff;

   logic rsp_valid_ff;
   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // line store: hit bit and range per pixel
   logic [MEM_W-1:0] line_store_ff [LINE_WIDTH];
   logic [MEM_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;

   assign rd_addr = (state_ff == ST_RD_LEFT) ? run_left_ff : xc_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         line_store_ff[idx_ff] <= {req_pixel_hit, req_pixel_range_mm};
      end
      rd_data_ff <= line_store_ff[rd_addr];
   end

   // run scan of one pixel
   logic [IDX_W-1:0]            scan_idx;
   logic                        scan_hit, scan_has_next, scan_start, scan_ends;
   logic [sbf_pkg::COLOR_W-1:0] scan_color;

   always_comb begin
      if (state_ff == ST_HELD) begin
         scan_idx      = idx_ff - IDX_W'(1);
         scan_hit      = held_hit_ff;
         scan_color    = held_color_ff;
         scan_has_next = 1'b1;
      end else begin
         scan_idx      = idx_ff;
         scan_hit      = cur_hit_ff;
         scan_color    = cur_color_ff;
         scan_has_next = 1'b0;
      end
      scan_start = !run_active_ff && scan_hit;
      // a one-pixel gap is bridged when the next pixel matches
      scan_ends  = run_active_ff && (scan_color != run_color_ff) &&
                   !(scan_has_next && (cur_color_ff == run_color_ff));
   end

   // shared units
   logic                        cordic_done, div_done;
   logic [sbf_pkg::ANGLE_W-1:0] cordic_angle;
   logic [sbf_pkg::QUO_W-1:0]   div_quot;
   logic [sbf_pkg::FOV_W-1:0]   fov_eff;

   assign fov_eff = (vfov_ff == '0) ? sbf_pkg::FOV_W'(1) : vfov_ff;

   sbf_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_CORDIC),
      .y_in  (half_height_ff),
      .x_in  (rng_ff),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   sbf_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DIV),
      .numer (p2_ff[sbf_pkg::PROD2_W-1:16]),
      .denom (fov_eff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // geometry helpers
   logic [8:0]                   half_h;
   logic [sbf_pkg::HEIGHT_W-1:0] h_max;
   logic [sbf_pkg::QUO_W:0]      bot_sum;

   assign half_h  = image_height_ff[sbf_pkg::HEIGHT_W-1:1];
   assign h_max   = (image_height_ff == '0) ? '0 : image_height_ff - 10'd1;
   assign bot_sum = (sbf_pkg::QUO_W+1)'(half_h) + (sbf_pkg::QUO_W+1)'(k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         idx_ff        <= '0;
         run_active_ff <= 1'b0;
         run_color_ff  <= '0;
         run_left_ff   <= '0;
         held_valid_ff <= 1'b0;
         held_hit_ff   <= 1'b0;
         held_color_ff <= '0;
         blob_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cur_hit_ff   <= req_pixel_hit;
                  cur_color_ff <= req_pixel_hit ? req_pixel_color : '0;
                  cur_last_ff  <= req_last_pixel || (idx_ff == IDX_W'(LINE_WIDTH - 1));
                  state_ff     <= ST_HELD;
               end
            end
            ST_HELD: begin
               state_ff <= ST_LAST;
               if (held_valid_ff && (idx_ff != '0)) begin
                  if (scan_start) begin
                     run_active_ff <= 1'b1;
                     run_color_ff  <= scan_color;
                     run_left_ff   <= scan_idx;
                  end else if (scan_ends) begin
                     run_active_ff <= 1'b0;
                     blob_right_ff <= scan_idx - IDX_W'(1);
                     ret_ff        <= ST_LAST;
                     state_ff      <= ST_BLOB_START;
                  end
               end
            end
            ST_LAST: begin
               if (!cur_last_ff) begin
                  held_valid_ff <= 1'b1;
                  held_hit_ff   <= cur_hit_ff;
                  held_color_ff <= cur_color_ff;
                  idx_ff        <= idx_ff + IDX_W'(1);
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= ST_FINAL;
                  if (scan_start) begin
                     run_active_ff <= 1'b1;
                     run_color_ff  <= scan_color;
                     run_left_ff   <= scan_idx;
                  end else if (scan_ends) begin
                     run_active_ff <= 1'b0;
                     blob_right_ff <= scan_idx - IDX_W'(1);
                     ret_ff        <= ST_FINAL;
                     state_ff      <= ST_BLOB_START;
                  end
               end
            end
            ST_FINAL: begin
               if (run_active_ff) begin
                  run_active_ff <= 1'b0;
                  blob_right_ff <= idx_ff;
                  ret_ff        <= ST_EOL;
                  state_ff      <= ST_BLOB_START;
               end else begin
                  state_ff <= ST_EOL;
               end
            end
            ST_EOL: begin
               rsp_is_blob       <= 1'b0;
               rsp_blob_id       <= sbf_pkg::ID_W'(blob_count_ff);
               rsp_blob_color    <= '0;
               rsp_x_center      <= '0;
               rsp_y_center      <= '0;
               rsp_left_edge     <= '0;
               rsp_right_edge    <= '0;
               rsp_top_edge      <= '0;
               rsp_bottom_edge   <= '0;
               rsp_blob_area     <= '0;
               rsp_blob_range_mm <= '0;
               rsp_last          <= 1'b1;
               rsp_valid_ff      <= 1'b1;
               idx_ff        <= '0;
               run_active_ff <= 1'b0;
               run_color_ff  <= '0;
               run_left_ff   <= '0;
               held_valid_ff <= 1'b0;
               held_hit_ff   <= 1'b0;
               held_color_ff <= '0;
               blob_count_ff <= '0;
               ret_ff        <= ST_IDLE;
               state_ff      <= ST_OUT;
            end
            ST_BLOB_START: begin
               // past the blob limit the run is closed but nothing is reported
               if (blob_count_ff >= CNT_W'(MAX_BLOBS)) begin
                  state_ff <= ret_ff;
               end else begin
                  xc_ff    <= run_left_ff + ((blob_right_ff - run_left_ff) >> 1);
                  state_ff <= ST_RD_CTR;
               end
            end
            ST_RD_CTR: state_ff <= ST_CHK_CTR;
            ST_CHK_CTR: begin
               if (rd_data_ff[MEM_W-1]) begin
                  rng_ff   <= rd_data_ff[sbf_pkg::RANGE_W-1:0];
                  state_ff <= ST_CORDIC;
               end else begin
                  state_ff <= ST_RD_LEFT;
               end
            end
            ST_RD_LEFT: state_ff <= ST_GET_LEFT;
            ST_GET_LEFT: begin
               rng_ff   <= rd_data_ff[sbf_pkg::RANGE_W-1:0];
               state_ff <= ST_CORDIC;
            end
            ST_CORDIC: state_ff <= ST_CORDIC_WAIT;
            ST_CORDIC_WAIT: begin
               if (cordic_done) begin
                  z_ff     <= cordic_angle;
                  state_ff <= ST_MUL_H;
               end
            end
            ST_MUL_H: begin
               p1_ff    <= sbf_pkg::PROD1_W'(z_ff) * sbf_pkg::PROD1_W'(image_height_ff);
               state_ff <= ST_MUL_K;
            end
            ST_MUL_K: begin
               p2_ff    <= sbf_pkg::PROD2_W'(p1_ff) * sbf_pkg::PROD2_W'(sbf_pkg::SCALE_MM);
               state_ff <= ST_DIV;
            end
            ST_DIV: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  k_ff     <= div_quot;
                  state_ff <= ST_EDGES;
               end
            end
            ST_EDGES: begin
               top_ff   <= (k_ff > sbf_pkg::QUO_W'(half_h)) ? '0 :
                           sbf_pkg::HEIGHT_W'(sbf_pkg::QUO_W'(half_h) - k_ff);
               bot_ff   <= (bot_sum > (sbf_pkg::QUO_W+1)'(h_max)) ? h_max :
                           bot_sum[sbf_pkg::HEIGHT_W-1:0];
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               rsp_is_blob       <= 1'b1;
               rsp_blob_id       <= sbf_pkg::ID_W'(blob_count_ff);
               rsp_blob_color    <= run_color_ff;
               rsp_x_center      <= sbf_pkg::EDGE_W'(xc_ff);
               rsp_y_center      <= half_h;
               rsp_left_edge     <= sbf_pkg::EDGE_W'(run_left_ff);
               rsp_right_edge    <= sbf_pkg::EDGE_W'(blob_right_ff);
               rsp_top_edge      <= top_ff;
               rsp_bottom_edge   <= bot_ff;
               rsp_blob_area     <= sbf_pkg::AREA_W'(bot_ff - top_ff) *
                                    sbf_pkg::AREA_W'(sbf_pkg::EDGE_W'(blob_right_ff - run_left_ff));
               rsp_blob_range_mm <= rng_ff;
               rsp_last          <= 1'b0;
               rsp_valid_ff      <= 1'b1;
               blob_count_ff     <= blob_count_ff + CNT_W'(1);
               state_ff          <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ret_ff;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

`include "assert_macros.svh"

   `SBF_ASSERT_IMPL(a_no_req_while_rsp, clock, reset, rsp_valid, req_stall)
   `SBF_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, blob_count_ff <= CNT_W'(MAX_BLOBS))
   `SBF_ASSERT_NEXT(a_eol_clears, clock, reset, rsp_valid && !rsp_stall && rsp_last, blob_count_ff == '0 && !run_active_ff && idx_ff == '0)

endmodule

[dv/tb_scanline_color_blob_finder_core.sv]
// Self-checking testbench for scanline_color_blob_finder_core: scan lines of pixel beats go
// through a queue-fed driver, a clocked monitor checks every record against a local predictor.
// Depends on sbf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_scanline_color_blob_finder_core;

   localparam int      LINE_W      = 256;
   localparam int      BLOB_CAP    = 64;
   localparam int      SAT_LEN     = 136;
   localparam int      DRAIN_WAIT  = 60;
   localparam longint  CYCLE_LIMIT = 400000;
   localparam longint  ANGLE_TAB[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2};

   typedef struct {
      bit          hit;
      logic [23:0] color;
      logic [15:0] rng;
      bit          last;
   } pixel_type;

   typedef struct {
      bit          is_blob;
      logic [6:0]  id;
      logic [23:0] color;
      logic [7:0]  xc;
      logic [8:0]  yc;
      logic [7:0]  left;
      logic [7:0]  right;
      logic [9:0]  top;
      logic [9:0]  bot;
      logic [17:0] area;
      logic [15:0] rng;
      bit          last;
   } blob_rec_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [sbf_pkg::CSR_IDX_W-1:0] csr_addr = '0;
   logic [sbf_pkg::CSR_W-1:0] csr_wr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic req_pixel_hit = 0;
   logic [sbf_pkg::COLOR_W-1:0] req_pixel_color = '0;
   logic [sbf_pkg::RANGE_W-1:0] req_pixel_range_mm = '0;
   logic req_last_pixel = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_is_blob;
   logic [sbf_pkg::ID_W-1:0] rsp_blob_id;
   logic [sbf_pkg::COLOR_W-1:0] rsp_blob_color;
   logic [sbf_pkg::EDGE_W-1:0] rsp_x_center;
   logic [8:0] rsp_y_center;
   logic [sbf_pkg::EDGE_W-1:0] rsp_left_edge;
   logic [sbf_pkg::EDGE_W-1:0] rsp_right_edge;
   logic [sbf_pkg::HEIGHT_W-1:0] rsp_top_edge;
   logic [sbf_pkg::HEIGHT_W-1:0] rsp_bottom_edge;
   logic [sbf_pkg::AREA_W-1:0] rsp_blob_area;
   logic [sbf_pkg::RANGE_W-1:0] rsp_blob_range_mm;
   logic rsp_last;

   scanline_color_blob_finder_core u_top (.*);

   always #5 clock = ~clock;

   pixel_type    pixel_q[$];
   pixel_type    on_bus;
   blob_rec_type blob_recs_due[$];
   int        fails = 0;
   bit        calm = 0;
   longint    cycles = 0;

   // predictor state
   logic [9:0]  cfg_height = sbf_pkg::RST_IMAGE_HEIGHT;
   logic [11:0] cfg_fov    = sbf_pkg::RST_VFOV;
   logic [11:0] cfg_half   = sbf_pkg::RST_HALF_HEIGHT;
   logic [15:0] range_mem[LINE_W];
   bit          hit_mem[LINE_W];
   int unsigned pix_idx = 0;
   bit          run_on = 0;
   logic [23:0] run_col = '0;
   int unsigned run_lft = 0;
   bit          held_v = 0;
   bit          held_hit = 0;
   logic [23:0] held_col = '0;
   int unsigned nblobs = 0;
   int          step_n;

   function automatic bit idle_now();
      return calm ? 1'b0 : ($urandom_range(99) < 28);
   endfunction

   function automatic longint atan2_q16(int unsigned yv, int unsigned xv);
      longint x, y, z, xs, ys;
      x = longint'(xv) * 65536;
      y = longint'(yv) * 65536;
      z = 0;
      if (yv == 0) return 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z += ANGLE_TAB[i];
         end else begin
            x = x - ys; y = y + xs; z -= ANGLE_TAB[i];
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic void emit_blob(int unsigned right);
      blob_rec_type r;
      int unsigned lft, xc, rng;
      longint z, fov, k, h, hmax, top, bot;
      if (nblobs >= BLOB_CAP || step_n >= 3) return;
      lft = run_lft;
      xc = (lft + (right - lft) / 2) & 8'hFF;
      rng = hit_mem[xc] ? range_mem[xc] : range_mem[lft & 8'hFF];
      z = atan2_q16(cfg_half, rng);
      fov = (cfg_fov != 0) ? longint'(cfg_fov) : 1;
      h = longint'(cfg_height);
      k = (z * h * 1000) / (fov * 65536);
      hmax = (h > 0) ? h - 1 : 0;
      top = h / 2 - k;
      bot = h / 2 + k;
      if (top < 0) top = 0;
      if (bot > hmax) bot = hmax;
      r.is_blob = 1;
      r.id = nblobs[6:0];
      r.color = run_col;
      r.xc = xc[7:0];
      r.yc = 9'(h / 2);
      r.left = lft[7:0];
      r.right = right[7:0];
      r.top = 10'(top);
      r.bot = 10'(bot);
      r.area = 18'((bot - top) * (longint'(right) - longint'(lft)));
      r.rng = rng[15:0];
      r.last = 0;
      blob_recs_due.push_back(r);
      nblobs++;
      step_n++;
   endfunction

   function automatic void scan_pixel(int unsigned idx, bit hit, logic [23:0] col,
                                      bit has_next, logic [23:0] next_col);
      if (!run_on) begin
         if (!hit) return;
         run_on = 1; run_col = col; run_lft = idx;
      end
      if (col == run_col || (has_next && next_col == run_col)) return;
      run_on = 0;
      emit_blob(idx - 1);
   endfunction

   function automatic void predict_pixel(pixel_type p);
      blob_rec_type eol;
      logic [23:0] col;
      int unsigned idx;
      bit last;
      col = p.hit ? p.color : 24'd0;
      idx = pix_idx & 8'hFF;
      last = p.last || idx >= LINE_W - 1;
      step_n = 0;
      range_mem[idx] = p.rng;
      hit_mem[idx] = p.hit;
      if (held_v && idx > 0) scan_pixel(idx - 1, held_hit, held_col, 1, col);
      if (!last) begin
         held_v = 1; held_hit = p.hit; held_col = col;
         pix_idx = idx + 1;
         return;
      end
      scan_pixel(idx, p.hit, col, 0, 24'd0);
      if (run_on) begin
         run_on = 0;
         emit_blob(idx);
      end
      eol = '{default: 0};
      eol.id = nblobs[6:0];
      eol.last = 1;
      blob_recs_due.push_back(eol);
      pix_idx = 0; run_on = 0; run_col = 0; run_lft = 0;
      held_v = 0; held_hit = 0; held_col = 0; nblobs = 0;
   endfunction

   function automatic void cmp(string nm, longint unsigned e, longint unsigned a);
      if (e != a) begin
         $error("%s: expected %0h, got %0h", nm, e, a);
         fails++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) predict_pixel(on_bus);
         if (!req_valid || !req_stall) begin
            if (pixel_q.size() > 0 && !idle_now()) begin
               on_bus = pixel_q.pop_front();
               req_valid <= 1;
               req_pixel_hit <= on_bus.hit;
               req_pixel_color <= on_bus.color;
               req_pixel_range_mm <= on_bus.rng;
               req_last_pixel <= on_bus.last;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      blob_rec_type e;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (blob_recs_due.size() == 0) begin
               $error("record beat with nothing expected");
               fails++;
            end else begin
               e = blob_recs_due.pop_front();
               cmp("is_blob", e.is_blob, rsp_is_blob);
               cmp("blob_id", e.id, rsp_blob_id);
               cmp("blob_color", e.color, rsp_blob_color);
               cmp("x_center", e.xc, rsp_x_center);
               cmp("y_center", e.yc, rsp_y_center);
               cmp("left_edge", e.left, rsp_left_edge);
               cmp("right_edge", e.right, rsp_right_edge);
               cmp("top_edge", e.top, rsp_top_edge);
               cmp("bottom_edge", e.bot, rsp_bottom_edge);
               cmp("blob_area", e.area, rsp_blob_area);
               cmp("blob_range_mm", e.rng, rsp_blob_range_mm);
               cmp("last", e.last, rsp_last);
            end
         end
         rsp_stall <= idle_now();
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("scanline_color_blob_finder_core verification failed");
         $finish;
      end
   end

   task automatic add_pixel(bit hit, logic [23:0] col, logic [15:0] rng, bit last);
      pixel_type p;
      p.hit = hit; p.color = col; p.rng = rng; p.last = last;
      pixel_q.push_back(p);
   endtask

   function automatic logic [15:0] pick_range();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 16'd0;
      if (r < 10) return 16'hFFFF;
      if (r < 60) return 16'($urandom_range(6000, 100));
      return 16'($urandom);
   endfunction

   task automatic add_line(int len);
      logic [23:0] pal[4];
      logic [23:0] cur;
      bit hit;
      int r;
      pal[0] = 24'd0;
      pal[1] = 24'($urandom);
      pal[2] = 24'($urandom);
      pal[3] = 24'hFFFFFF;
      cur = pal[$urandom_range(3)];
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(99);
         hit = 1;
         if (r < 55) begin
         end else if (r < 72) begin
            hit = 0;
         end else if (r < 90) begin
            cur = pal[$urandom_range(3)];
         end else begin
            cur = 24'($urandom);
         end
         // misses still carry random color bits; the block must ignore them
         add_pixel(hit, hit ? cur : 24'($urandom), pick_range(), i == len - 1);
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pixel_q.size() > 0 || req_valid || blob_recs_due.size() > 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_regs(logic [9:0] h, logic [11:0] f, logic [11:0] t);
      @(posedge clock);
      csr_wr_en <= 1; csr_addr <= sbf_pkg::CSR_IMAGE_HEIGHT;
      csr_wr_data <= sbf_pkg::CSR_W'(h);
      @(posedge clock);
      csr_addr <= sbf_pkg::CSR_VFOV; csr_wr_data <= f;
      @(posedge clock);
      csr_addr <= sbf_pkg::CSR_HALF_HEIGHT; csr_wr_data <= t;
      @(posedge clock);
      csr_wr_en <= 0;
      cfg_height = h; cfg_fov = f; cfg_half = t;
   endtask

   task automatic random_lines(int items);
      int sent, len;
      sent = 0;
      while (sent < items) begin
         len = $urandom_range(2, 16);
         add_line(len);
         sent += len;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      write_regs(sbf_pkg::RST_IMAGE_HEIGHT, sbf_pkg::RST_VFOV, sbf_pkg::RST_HALF_HEIGHT);

      // directed: extremes, gap bridging, black hits, zero range, one-pixel lines
      add_pixel(1, 24'hFFFFFF, 16'hFFFF, 0);
      add_pixel(1, 24'hFFFFFF, 16'd0, 0);
      add_pixel(1, 24'h123456, 16'd500, 1);
      add_pixel(1, 24'hA5A5A5, 16'd0, 1);
      add_pixel(0, 24'hFFFFFF, 16'hFFFF, 1);
      add_pixel(1, 24'h00FF00, 16'd1000, 0);
      add_pixel(1, 24'h0000FF, 16'd1200, 0);
      add_pixel(1, 24'h00FF00, 16'd1400, 0);
      add_pixel(0, 24'h0, 16'd10, 0);
      add_pixel(0, 24'h0, 16'd20, 0);
      add_pixel(1, 24'h0, 16'd3000, 0);
      add_pixel(0, 24'h5A5A5A, 16'd3100, 0);
      add_pixel(1, 24'h0, 16'd0, 0);
      add_pixel(1, 24'h777777, 16'd800, 0);
      add_pixel(0, 24'h0, 16'd0, 1);
      add_pixel(0, 24'h0, 16'd1, 0);
      add_pixel(1, 24'h808080, 16'd65535, 1);
      add_pixel(1, 24'h111111, 16'd700, 0);
      add_pixel(1, 24'h222222, 16'd700, 0);
      add_pixel(1, 24'h333333, 16'd700, 1);
      drain();

      write_regs(10'd1023, 12'd3142, 12'd4095);
      random_lines(10);
      drain();

      // three rotating colors close a blob every two pixels: more blobs than fit
      write_regs(10'd1, 12'd1, 12'd1);
      for (int i = 0; i < SAT_LEN; i++)
         add_pixel(1, (i % 3 == 0) ? 24'hC0FFEE : ((i % 3 == 1) ? 24'h00C0DE : 24'hBADA55),
                   pick_range(), i == SAT_LEN - 1);
      drain();

      write_regs(10'd0, 12'd0, 12'd4095);
      random_lines(10);
      drain();

      calm = 1;
      write_regs(10'd480, 12'd1, 12'd1);
      random_lines(10);
      drain();
      calm = 0;

      write_regs(10'($urandom_range(1023, 1)), 12'($urandom_range(3142, 1)),
                 12'($urandom_range(4095, 1)));
      random_lines(10);
      drain();

      if (fails == 0)
         $display("scanline_color_blob_finder_core verification clean");
      else
         $display("scanline_color_blob_finder_core verification failed");
      $finish;
   end

endmodule
